/* hdl/rstb_pkg.sv */
// Shared types and constants for the range sum tree bank.
package rstb_pkg;

    localparam int SLOTS_DEF = 1024;
    localparam int IDX_W     = 10;
    localparam int AMT_W     = 32;
    localparam int SUM_W     = 42;
    localparam int CNT_W     = 11;

    localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;
    localparam logic [AMT_W-1:0] SLOT_MAX  = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        OP_SET      = 2'd0,
        OP_WITHDRAW = 2'd1,
        OP_DEPOSIT  = 2'd2,
        OP_RANGE    = 2'd3
    } t_op;

    // One checked operation handed from the front end to the engine.
    typedef struct packed {
        t_op              op;
        logic             bad;
        logic [IDX_W-1:0] index;
        logic [IDX_W-1:0] upper;
        logic [AMT_W-1:0] amount;
    } t_cmd;

    typedef struct packed {
        logic [SUM_W-1:0] value;
        logic             status;
    } t_res;

endpackage

/* hdl/rstb_engine.sv */
// Tree memory with its clearing pass, update walk and range query sequencer.
module rstb_engine #(
    parameter int SLOTS = rstb_pkg::SLOTS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    output logic            o_cmd_ready,
    input  rstb_pkg::t_cmd  i_cmd,
    output logic            o_res_valid,
    output rstb_pkg::t_res  o_res,
    input  logic            i_res_take
);

    localparam int DEPTH = 2 * SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = $clog2(DEPTH + 1);
    localparam int SW    = rstb_pkg::SUM_W;
    localparam int MW    = rstb_pkg::AMT_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LEAF,
        S_UPD,
        S_WALK,
        S_QUERY,
        S_OUT
    } t_state;

    t_state          r_state;
    rstb_pkg::t_op   r_op;
    logic [MW-1:0]   r_amount;
    logic [PW-1:0]   r_lptr;
    logic [PW-1:0]   r_rptr;
    logic            r_phase;
    logic            r_pend;
    logic [SW-1:0]   r_acc;
    logic [SW-1:0]   r_cur;
    rstb_pkg::t_res  r_res;
    logic [AW-1:0]   r_clr;
    logic [SW-1:0]   r_rd_data;
    logic [SW-1:0]   r_mem [DEPTH];

    logic [SW-1:0]   n_acc;
    logic [PW-1:0]   parent;
    logic [PW-1:0]   rptr_dec;
    logic [SW-1:0]   walk_sum;
    logic [MW:0]     dep_sum;
    logic [MW-1:0]   leaf_new;

    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [SW-1:0]   wr_data;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;

    assign n_acc    = r_acc + (r_pend ? r_rd_data : '0);
    assign parent   = r_lptr >> 1;
    assign rptr_dec = r_rptr - PW'(1);
    assign walk_sum = r_cur + r_rd_data;
    assign dep_sum  = {1'b0, r_rd_data[MW-1:0]} + {1'b0, r_amount};

    always_comb begin
        case (r_op)
            rstb_pkg::OP_SET:     leaf_new = r_amount;
            rstb_pkg::OP_DEPOSIT: leaf_new = dep_sum[MW] ? rstb_pkg::SLOT_MAX : dep_sum[MW-1:0];
            default:              leaf_new = '0;
        endcase
    end

    // Memory port control: one write and one read address per cycle.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_clr;
        wr_data = '0;
        rd_en   = 1'b0;
        rd_addr = r_lptr[AW-1:0];
        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
            end
            S_LEAF: begin
                rd_en = 1'b1;
            end
            S_UPD: begin
                wr_en   = 1'b1;
                wr_addr = r_lptr[AW-1:0];
                wr_data = SW'(leaf_new);
                rd_en   = 1'b1;
                rd_addr = r_lptr[AW-1:0] ^ AW'(1);
            end
            S_WALK: begin
                wr_en   = 1'b1;
                wr_addr = parent[AW-1:0];
                wr_data = walk_sum;
                rd_en   = (parent != PW'(1));
                rd_addr = parent[AW-1:0] ^ AW'(1);
            end
            S_QUERY: begin
                if (!r_phase) begin
                    rd_en   = (r_lptr < r_rptr) && r_lptr[0];
                    rd_addr = r_lptr[AW-1:0];
                end else begin
                    rd_en   = r_rptr[0];
                    rd_addr = rptr_dec[AW-1:0];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        r_op     <= i_cmd.op;
                        r_amount <= i_cmd.amount;
                        r_lptr   <= PW'(SLOTS) + PW'(i_cmd.index);
                        r_rptr   <= PW'(SLOTS) + PW'(i_cmd.upper) + PW'(1);
                        r_acc    <= '0;
                        r_pend   <= 1'b0;
                        r_phase  <= 1'b0;
                        if (i_cmd.bad) begin
                            r_res   <= '{value: '0, status: 1'b1};
                            r_state <= S_OUT;
                        end else if (i_cmd.op == rstb_pkg::OP_RANGE) begin
                            if (i_cmd.index > i_cmd.upper) begin
                                r_res   <= '{value: '0, status: 1'b0};
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_QUERY;
                            end
                        end else begin
                            r_state <= S_LEAF;
                        end
                    end
                end
                S_LEAF: begin
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_cur   <= SW'(leaf_new);
                    r_res   <= '{value: r_rd_data, status: 1'b0};
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    r_cur  <= walk_sum;
                    r_lptr <= parent;
                    if (parent == PW'(1)) begin
                        r_state <= (r_op == rstb_pkg::OP_WITHDRAW) ? S_OUT : S_IDLE;
                    end
                end
                S_QUERY: begin
                    r_acc <= n_acc;
                    if (!r_phase) begin
                        if (r_lptr >= r_rptr) begin
                            r_res   <= '{value: n_acc, status: 1'b0};
                            r_state <= S_OUT;
                        end else begin
                            r_pend  <= r_lptr[0];
                            r_phase <= 1'b1;
                            if (r_lptr[0]) begin
                                r_lptr <= r_lptr + PW'(1);
                            end
                        end
                    end else begin
                        // An odd right bound steps down before the shift; both give r/2.
                        r_pend  <= r_rptr[0];
                        r_lptr  <= r_lptr >> 1;
                        r_rptr  <= r_rptr >> 1;
                        r_phase <= 1'b0;
                    end
                end
                S_OUT: begin
                    if (i_res_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cmd_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_OUT);
    assign o_res       = r_res;

endmodule

/* hdl/range_sum_tree_bank_top.sv */
// Top level of the range sum tree bank: configuration, range checks and result register.
//
//  Channel   Direction  Handshake                   Payload
//  config    in         i_cfg_we                    i_cfg_wdata (slot_count)
//  in        in         i_in_valid / o_in_stall     i_operation, i_index, i_upper_index,
//                                                   i_amount
//  out       out        o_out_valid / i_out_stall   o_result_value, o_status
//
// One item is worked at a time; the single-port-per-direction tree memory sets the pace.
// A set or deposit reads its leaf, then walks to the root one tree level per cycle,
// writing each node sum on the way; a withdraw does the same and then presents its result.
// A range sum takes a left-bound step and a right-bound step per tree level it climbs.
// An index error or reversed bounds goes straight to the result.
// After reset a clearing pass writes zero to all 2*SLOTS tree entries before the first
// input transfer is taken; configuration writes work throughout.
// Under output stall one result waits in the output register; a second result holds the
// engine, and the input stalls until the register drains.
module range_sum_tree_bank_top #(
    parameter int SLOTS = rstb_pkg::SLOTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rstb_pkg::CNT_W-1:0]  i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [1:0]                  i_operation,
    input  logic [rstb_pkg::IDX_W-1:0]  i_index,
    input  logic [rstb_pkg::IDX_W-1:0]  i_upper_index,
    input  logic [rstb_pkg::AMT_W-1:0]  i_amount,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [rstb_pkg::SUM_W-1:0]  o_result_value,
    output logic                        o_status
);

    logic [rstb_pkg::CNT_W-1:0] r_slot_count;
    logic                       r_out_valid;
    logic [rstb_pkg::SUM_W-1:0] r_out_value;
    logic                       r_out_status;

    logic [31:0]    count_eff;
    rstb_pkg::t_cmd cmd;
    logic           cmd_ready;
    logic           res_valid;
    rstb_pkg::t_res res;
    logic           res_take;

    // Slot counts above the bank size act as the bank size; zero rejects every index.
    assign count_eff = (32'(r_slot_count) > 32'(SLOTS)) ? 32'(SLOTS) : 32'(r_slot_count);

    always_comb begin
        cmd.op     = rstb_pkg::t_op'(i_operation);
        cmd.index  = i_index;
        cmd.upper  = i_upper_index;
        cmd.amount = i_amount;
        cmd.bad    = (32'(i_index) >= count_eff)
                  || ((cmd.op == rstb_pkg::OP_RANGE) && (32'(i_upper_index) >= count_eff));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_count <= rstb_pkg::CNT_RESET;
        end else if (i_cfg_we) begin
            r_slot_count <= i_cfg_wdata;
        end
    end

    // The engine hands over a result only when the output register is free or draining.
    assign res_take = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_take) begin
            r_out_valid  <= 1'b1;
            r_out_value  <= res.value;
            r_out_status <= res.status;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Node sums never exceed 1024 slots of 32 bits, so totals fit the 42-bit result.
    rstb_engine #(
        .SLOTS (SLOTS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_in_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take)
    );

    assign o_in_stall     = !cmd_ready;
    assign o_out_valid    = r_out_valid;
    assign o_result_value = r_out_value;
    assign o_status       = r_out_status;

endmodule
